// File: sv/mdpd_pkg.sv
package mdpd_pkg;

   // Fixed field widths of the ports.
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 19;
   localparam int BASE_THR_W   = 12;
   localparam int MAX_BAD_W    = 19;
   localparam int DIM_W        = 10;
   localparam int PIX_PORT_W   = 16;
   localparam int CNT_PORT_W   = 19;
   localparam int THR_W        = 17;
   localparam int COORD_PORT_W = 9;
   localparam int KIND_W       = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BAD_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT   = 2'd3;

   localparam logic [BASE_THR_W-1:0] RST_BASE_THRESHOLD = 12'd64;
   localparam logic [MAX_BAD_W-1:0]  RST_MAX_BAD_COUNT  = 19'd1024;
   localparam logic [DIM_W-1:0]      RST_FRAME_WIDTH    = 10'd512;
   localparam logic [DIM_W-1:0]      RST_FRAME_HEIGHT   = 10'd512;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam int THR_SHIFT = 4;
   localparam int MIN_DIM   = 7;
   localparam int EDGE_BAND = 3;

   // Window geometry: small window near the edges, large one inside.
   localparam logic [2:0] SIDE_SMALL   = 3'd3;
   localparam logic [2:0] SIDE_LARGE   = 3'd7;
   localparam logic [2:0] RADIUS_SMALL = 3'd1;
   localparam logic [2:0] RADIUS_LARGE = 3'd3;
   localparam logic [5:0] WIN_SMALL    = 6'd9;
   localparam logic [5:0] WIN_LARGE    = 6'd49;
   localparam logic [5:0] RANK_SMALL   = 6'd4;
   localparam logic [5:0] RANK_LARGE   = 6'd24;

   // Repair-direction codes.
   localparam logic [KIND_W-1:0] KIND_ISOLATED   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HORIZONTAL = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VERTICAL   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UP         = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RIGHT      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LEFT       = 3'd5;
   localparam logic [KIND_W-1:0] KIND_DOWN       = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SURROUNDED = 3'd7;

   // Neighbour fetch order.
   localparam logic [1:0] NB_UP    = 2'd0;
   localparam logic [1:0] NB_DOWN  = 2'd1;
   localparam logic [1:0] NB_LEFT  = 2'd2;
   localparam logic [1:0] NB_RIGHT = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_HCLR,
      ST_CTR,
      ST_CTRW,
      ST_MED,
      ST_MBIT,
      ST_DEV,
      ST_HINC,
      ST_SUFR,
      ST_SUFW,
      ST_THR,
      ST_THRC,
      ST_MAPR,
      ST_MAPW,
      ST_DONE,
      ST_SCR,
      ST_SCC,
      ST_NBR,
      ST_NBC,
      ST_KIND,
      ST_RESP
   } state_type;

endpackage

// File: sv/mdpd_ram.sv
module mdpd_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024,
   localparam int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/median_defect_pixel_detector.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_action, req_pixel_value
// rsp      out        rsp_valid/rsp_ready    detect_done, bad_count, final_threshold, point fields
// csr      in         csr_wr_en              csr_index, csr_wdata
//
// A pixel load that does not complete the frame gets a response with detect_done low, and loads follow
// back to back while rsp_ready is high. The load that completes the frame starts detection: a clearing
// pass over the histogram memory, a bitwise median search through the single frame memory read port,
// a deviation histogram, a suffix sum of the histogram, the threshold passes and a pass that writes
// the bad map. A read transfer scans the bad-map entries and reads the four neighbours of an inner
// point. Reset is synchronous; the result register waits for rsp_ready without blocking a new request
// once it has been taken.
module median_defect_pixel_detector #(
   parameter int MAX_WIDTH      = 512,
   parameter int MAX_HEIGHT     = 512,
   parameter int PIXEL_BITS     = 16,
   parameter int THRESHOLD_STEP = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic [mdpd_pkg::PIX_PORT_W-1:0]       req_pixel_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_detect_done,
   output logic [mdpd_pkg::CNT_PORT_W-1:0]       rsp_bad_count,
   output logic [mdpd_pkg::THR_W-1:0]            rsp_final_threshold,
   output logic                                  rsp_point_valid,
   output logic [mdpd_pkg::COORD_PORT_W-1:0]     rsp_point_x,
   output logic [mdpd_pkg::COORD_PORT_W-1:0]     rsp_point_y,
   output logic [mdpd_pkg::KIND_W-1:0]           rsp_point_type,
   output logic                                  rsp_list_end,
   input  logic                                  csr_wr_en,
   input  logic [mdpd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mdpd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import mdpd_pkg::*;

   localparam int NPIX   = MAX_WIDTH * MAX_HEIGHT;
   localparam int IW     = $clog2(NPIX);
   localparam int NW     = $clog2(NPIX + 1);
   localparam int PB     = PIXEL_BITS;
   localparam int NLEVEL = 1 << PIXEL_BITS;
   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int WDW    = $clog2(MAX_WIDTH + 1);
   localparam int HDW    = $clog2(MAX_HEIGHT + 1);
   localparam int CWW    = (WDW > DIM_W) ? WDW : DIM_W;
   localparam int CHW    = (HDW > DIM_W) ? HDW : DIM_W;
   localparam int MW     = (NW > MAX_BAD_W) ? NW : MAX_BAD_W;
   localparam int RW     = YW + 4;
   localparam int CW     = XW + 4;
   localparam int PW     = YW + WDW + 1;

   // Control state.
   state_type state_ff, state_in;
   logic [BASE_THR_W-1:0] base_ff;
   logic [MAX_BAD_W-1:0]  max_bad_ff;
   logic [DIM_W-1:0]      fw_ff, fh_ff;
   logic [IW-1:0]  load_idx_ff, load_idx_in;
   logic           finished_ff, finished_in;
   logic [NW-1:0]  found_ff, found_in;
   logic [THR_W-1:0] cur_thr_ff, cur_thr_in;
   logic [NW-1:0]  read_idx_ff, read_idx_in;
   logic           va_ff, va_in, vb_ff, vc_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [WDW-1:0] det_w_ff, det_w_in;
   logic [HDW-1:0] det_h_ff, det_h_in;
   logic [NW-1:0]  det_total_ff, det_total_in;
   logic [XW-1:0]  cx_ff, cx_in, sx_ff, sx_in;
   logic [YW-1:0]  cy_ff, cy_in, sy_ff, sy_in;
   logic [IW-1:0]  pos_ff, pos_in;
   logic [NW-1:0]  scan_ff, scan_in;
   logic           big_ff, big_in;
   logic [2:0]     wx_ff, wx_in, wy_ff, wy_in;
   logic           iss_done_ff, iss_done_in;
   logic [5:0]     cnt_ff, cnt_in, cons_ff, cons_in, k_ff, k_in;
   logic [PB-1:0]  prefix_ff, prefix_in, mask_ff, mask_in, bsel_ff, bsel_in;
   logic [PB-1:0]  pix_ff, pix_in, d_ff, d_in, idx_ff, idx_in;
   logic [YW-1:0]  ra_row_ff, ra_row_in;
   logic [XW-1:0]  ra_col_ff, ra_col_in;
   logic [IW-1:0]  addr_ff;
   logic [NW-1:0]  acc_ff, acc_in, s_ff, s_in, pass_ff, pass_in;
   logic [THR_W-1:0] thr_ff, thr_in, used_ff, used_in;
   logic [3:0]     nb_ff, nb_in;
   logic [1:0]     nb_idx_ff, nb_idx_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic           pt_ok_ff, pt_ok_in;

   // Result register.
   logic                    r_done_ff, r_done_in;
   logic [CNT_PORT_W-1:0]   r_count_ff, r_count_in;
   logic [THR_W-1:0]        r_thr_ff, r_thr_in;
   logic                    r_pvalid_ff, r_pvalid_in;
   logic [COORD_PORT_W-1:0] r_x_ff, r_x_in, r_y_ff, r_y_in;
   logic [KIND_W-1:0]       r_kind_ff, r_kind_in;
   logic                    r_last_ff, r_last_in;

   // Memory ports.
   logic          fr_we;
   logic [IW-1:0] fr_waddr;
   logic [PB-1:0] fr_rdata;
   logic          dv_we;
   logic [PB-1:0] dv_rdata;
   logic          bm_we, bm_wdata;
   logic [IW-1:0] bm_raddr;
   logic          bm_rdata;
   logic          hg_we;
   logic [PB-1:0] hg_waddr, hg_raddr;
   logic [NW-1:0] hg_wdata, hg_rdata;

   // Shared helpers.
   logic           out_free, accept, is_load, eligible, last_load;
   logic [WDW-1:0] w_eff;
   logic [HDW-1:0] h_eff;
   logic [NW-1:0]  total_now, load_base, load_next;
   logic [2:0]     side, radius;
   logic [5:0]     win_n;
   logic           match, med_last, last_pix, pos_last, sx_last;
   logic [PB-1:0]  dev_val;
   logic [RW-1:0]  rb;
   logic [CW-1:0]  cb;
   logic [YW-1:0]  row_m;
   logic [XW-1:0]  col_m;
   logic [PW-1:0]  prod;
   logic [NW-1:0]  s_now;
   logic           over_max, pass_end, edge_pt, big_now;
   logic [KIND_W-1:0] edge_kind;
   logic [THR_W-1:0]  thr_step;

   always_comb begin
      if (fw_ff < DIM_W'(MIN_DIM)) begin
         w_eff = WDW'(MIN_DIM);
      end else if (CWW'(fw_ff) > CWW'(MAX_WIDTH)) begin
         w_eff = WDW'(MAX_WIDTH);
      end else begin
         w_eff = WDW'(fw_ff);
      end
      if (fh_ff < DIM_W'(MIN_DIM)) begin
         h_eff = HDW'(MIN_DIM);
      end else if (CHW'(fh_ff) > CHW'(MAX_HEIGHT)) begin
         h_eff = HDW'(MAX_HEIGHT);
      end else begin
         h_eff = HDW'(fh_ff);
      end
   end

   assign total_now = NW'(w_eff * h_eff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign is_load   = (req_action == ACT_LOAD);
   assign eligible  = finished_ff && (read_idx_ff < found_ff);
   assign load_base = finished_ff ? '0 : NW'(load_idx_ff);
   assign load_next = load_base + NW'(1);
   assign last_load = (load_next >= total_now);

   assign side   = big_ff ? SIDE_LARGE : SIDE_SMALL;
   assign radius = big_ff ? RADIUS_LARGE : RADIUS_SMALL;
   assign win_n  = big_ff ? WIN_LARGE : WIN_SMALL;

   // Window position with the two-pixel mirror at the frame border.
   assign rb = RW'(cy_ff) + RW'(wy_ff) + RW'(2) - RW'(radius);
   assign cb = CW'(cx_ff) + CW'(wx_ff) + CW'(2) - CW'(radius);
   always_comb begin
      if (rb < RW'(2)) begin
         row_m = YW'(rb);
      end else if (rb > RW'(det_h_ff) + RW'(1)) begin
         row_m = YW'(rb - RW'(4));
      end else begin
         row_m = YW'(rb - RW'(2));
      end
      if (cb < CW'(2)) begin
         col_m = XW'(cb);
      end else if (cb > CW'(det_w_ff) + CW'(1)) begin
         col_m = XW'(cb - CW'(4));
      end else begin
         col_m = XW'(cb - CW'(2));
      end
   end

   assign prod = PW'(ra_row_ff) * PW'(det_w_ff) + PW'(ra_col_ff);

   assign big_now = !((cy_ff < YW'(EDGE_BAND)) ||
                      (RW'(cy_ff) >= RW'(det_h_ff) - RW'(EDGE_BAND)) ||
                      (cx_ff < XW'(EDGE_BAND)) ||
                      (CW'(cx_ff) >= CW'(det_w_ff) - CW'(EDGE_BAND)));

   // One bit of the median per pass over the window.
   assign match    = (((fr_rdata ^ prefix_ff) & mask_ff) == '0) && ((fr_rdata & bsel_ff) == '0);
   assign med_last = vc_ff && (cons_ff == win_n - 6'd1);
   assign dev_val  = (pix_ff > prefix_ff) ? (pix_ff - prefix_ff) : (prefix_ff - pix_ff);
   assign last_pix = (NW'(pos_ff) == det_total_ff - NW'(1));
   assign pos_last = last_pix;
   assign sx_last  = (WDW'(sx_ff) == det_w_ff - WDW'(1));

   assign thr_step = THR_W'(THRESHOLD_STEP);
   assign s_now    = (thr_ff >= THR_W'(NLEVEL)) ? '0 : hg_rdata;
   assign over_max = (MW'(s_now) > MW'(max_bad_ff));
   assign pass_end = (pass_ff + NW'(1) >= det_total_ff);

   always_comb begin
      edge_pt   = 1'b1;
      edge_kind = KIND_DOWN;
      if (sy_ff == '0) begin
         edge_kind = KIND_DOWN;
      end else if (sx_ff == '0) begin
         edge_kind = KIND_RIGHT;
      end else if (sx_last) begin
         edge_kind = KIND_LEFT;
      end else if (HDW'(sy_ff) == det_h_ff - HDW'(1)) begin
         edge_kind = KIND_UP;
      end else begin
         edge_pt = 1'b0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_load && last_load) begin
                  state_in = ST_HCLR;
               end else if (!is_load && eligible) begin
                  state_in = ST_SCR;
               end
            end
         end
         ST_HCLR: if (idx_ff == {PB{1'b1}}) state_in = ST_CTR;
         ST_CTR:  state_in = ST_CTRW;
         ST_CTRW: if (vc_ff) state_in = ST_MED;
         ST_MED:  if (med_last) state_in = ST_MBIT;
         ST_MBIT: state_in = bsel_ff[0] ? ST_DEV : ST_MED;
         ST_DEV:  state_in = ST_HINC;
         ST_HINC: state_in = last_pix ? ST_SUFR : ST_CTR;
         ST_SUFR: state_in = ST_SUFW;
         ST_SUFW: state_in = (idx_ff == '0) ? ST_THR : ST_SUFR;
         ST_THR:  state_in = ST_THRC;
         ST_THRC: state_in = (over_max && !pass_end) ? ST_THR : ST_MAPR;
         ST_MAPR: state_in = ST_MAPW;
         ST_MAPW: state_in = pos_last ? ST_DONE : ST_MAPR;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         ST_SCR:  state_in = (scan_ff < det_total_ff) ? ST_SCC : ST_RESP;
         ST_SCC: begin
            if (bm_rdata) begin
               state_in = edge_pt ? ST_RESP : ST_NBR;
            end else begin
               state_in = ST_SCR;
            end
         end
         ST_NBR:  state_in = ST_NBC;
         ST_NBC:  state_in = (nb_idx_ff == NB_RIGHT) ? ST_KIND : ST_NBR;
         ST_KIND: state_in = ST_RESP;
         ST_RESP: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      load_idx_in = load_idx_ff;
      finished_in = finished_ff;
      found_in    = found_ff;
      cur_thr_in  = cur_thr_ff;
      read_idx_in = read_idx_ff;
      va_in       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      det_w_in    = det_w_ff;
      det_h_in    = det_h_ff;
      det_total_in = det_total_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  pos_in = pos_ff;
      sx_in = sx_ff;  sy_in = sy_ff;  scan_in = scan_ff;
      big_in = big_ff;
      wx_in = wx_ff;  wy_in = wy_ff;  iss_done_in = iss_done_ff;
      cnt_in = cnt_ff;  cons_in = cons_ff;  k_in = k_ff;
      prefix_in = prefix_ff;  mask_in = mask_ff;  bsel_in = bsel_ff;
      pix_in = pix_ff;  d_in = d_ff;  idx_in = idx_ff;
      ra_row_in = ra_row_ff;  ra_col_in = ra_col_ff;
      acc_in = acc_ff;  s_in = s_ff;  pass_in = pass_ff;
      thr_in = thr_ff;  used_in = used_ff;
      nb_in = nb_ff;  nb_idx_in = nb_idx_ff;  kind_in = kind_ff;  pt_ok_in = pt_ok_ff;
      r_done_in = r_done_ff;  r_count_in = r_count_ff;  r_thr_in = r_thr_ff;
      r_pvalid_in = r_pvalid_ff;  r_x_in = r_x_ff;  r_y_in = r_y_ff;
      r_kind_in = r_kind_ff;  r_last_in = r_last_ff;
      fr_we = 1'b0;
      fr_waddr = IW'(load_base);
      dv_we = 1'b0;
      bm_we = 1'b0;
      bm_wdata = (THR_W'(dv_rdata) >= used_ff);
      bm_raddr = IW'(scan_ff);
      hg_we = 1'b0;
      hg_waddr = idx_ff;
      hg_wdata = '0;
      hg_raddr = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_load) begin
                  fr_we = 1'b1;
                  if (finished_ff) begin
                     finished_in = 1'b0;
                     read_idx_in = '0;
                     found_in    = '0;
                     cur_thr_in  = '0;
                  end
                  if (last_load) begin
                     load_idx_in  = '0;
                     det_w_in     = w_eff;
                     det_h_in     = h_eff;
                     det_total_in = total_now;
                     idx_in = '0;
                     cx_in  = '0;
                     cy_in  = '0;
                     pos_in = '0;
                  end else begin
                     load_idx_in  = IW'(load_next);
                     rsp_valid_in = 1'b1;
                     r_done_in    = 1'b0;
                     r_count_in   = '0;
                     r_thr_in     = '0;
                     r_pvalid_in  = 1'b0;
                     r_x_in       = '0;
                     r_y_in       = '0;
                     r_kind_in    = '0;
                     r_last_in    = 1'b0;
                  end
               end else if (!eligible) begin
                  rsp_valid_in = 1'b1;
                  r_done_in    = finished_ff;
                  r_count_in   = finished_ff ? CNT_PORT_W'(found_ff) : '0;
                  r_thr_in     = finished_ff ? cur_thr_ff : '0;
                  r_pvalid_in  = 1'b0;
                  r_x_in       = '0;
                  r_y_in       = '0;
                  r_kind_in    = '0;
                  r_last_in    = 1'b0;
               end
            end
         end
         ST_HCLR: begin
            hg_we  = 1'b1;
            idx_in = idx_ff + PB'(1);
         end
         ST_CTR: begin
            ra_row_in = cy_ff;
            ra_col_in = cx_ff;
            va_in     = 1'b1;
            big_in    = big_now;
         end
         ST_CTRW: begin
            if (vc_ff) begin
               pix_in      = fr_rdata;
               k_in        = big_ff ? RANK_LARGE : RANK_SMALL;
               prefix_in   = '0;
               mask_in     = '0;
               bsel_in     = {1'b1, {(PB-1){1'b0}}};
               wx_in       = '0;
               wy_in       = '0;
               iss_done_in = 1'b0;
               cnt_in      = '0;
               cons_in     = '0;
            end
         end
         ST_MED: begin
            if (!iss_done_ff) begin
               ra_row_in = row_m;
               ra_col_in = col_m;
               va_in     = 1'b1;
               if (wx_ff == side - 3'd1) begin
                  wx_in = '0;
                  wy_in = wy_ff + 3'd1;
                  if (wy_ff == side - 3'd1) begin
                     iss_done_in = 1'b1;
                  end
               end else begin
                  wx_in = wx_ff + 3'd1;
               end
            end
            if (vc_ff) begin
               cons_in = cons_ff + 6'd1;
               if (match) begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
         end
         ST_MBIT: begin
            if (k_ff >= cnt_ff) begin
               prefix_in = prefix_ff | bsel_ff;
               k_in      = k_ff - cnt_ff;
            end
            mask_in     = mask_ff | bsel_ff;
            bsel_in     = bsel_ff >> 1;
            wx_in       = '0;
            wy_in       = '0;
            iss_done_in = 1'b0;
            cnt_in      = '0;
            cons_in     = '0;
         end
         ST_DEV: begin
            dv_we    = 1'b1;
            hg_raddr = dev_val;
            d_in     = dev_val;
         end
         ST_HINC: begin
            hg_we    = 1'b1;
            hg_waddr = d_ff;
            hg_wdata = hg_rdata + NW'(1);
            if (last_pix) begin
               idx_in = {PB{1'b1}};
               acc_in = '0;
            end else begin
               pos_in = pos_ff + IW'(1);
               if (WDW'(cx_ff) == det_w_ff - WDW'(1)) begin
                  cx_in = '0;
                  cy_in = cy_ff + YW'(1);
               end else begin
                  cx_in = cx_ff + XW'(1);
               end
            end
         end
         ST_SUFR: begin
            hg_raddr = idx_ff;
         end
         ST_SUFW: begin
            acc_in   = acc_ff + hg_rdata;
            hg_we    = 1'b1;
            hg_wdata = acc_ff + hg_rdata;
            idx_in   = idx_ff - PB'(1);
            if (idx_ff == '0) begin
               thr_in  = THR_W'(base_ff) << THR_SHIFT;
               pass_in = NW'(1);
            end
         end
         ST_THR: begin
            hg_raddr = thr_ff[PB-1:0];
         end
         ST_THRC: begin
            s_in = s_now;
            if (over_max) begin
               if (pass_end) begin
                  used_in    = thr_ff;
                  cur_thr_in = thr_ff + thr_step;
                  pos_in     = '0;
               end else begin
                  thr_in  = thr_ff + thr_step;
                  pass_in = pass_ff + NW'(1);
               end
            end else begin
               used_in    = thr_ff;
               cur_thr_in = thr_ff;
               pos_in     = '0;
            end
         end
         ST_MAPR: begin
         end
         ST_MAPW: begin
            bm_we = 1'b1;
            if (!pos_last) begin
               pos_in = pos_ff + IW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               finished_in  = 1'b1;
               found_in     = s_ff;
               read_idx_in  = '0;
               scan_in      = '0;
               sx_in        = '0;
               sy_in        = '0;
               rsp_valid_in = 1'b1;
               r_done_in    = 1'b1;
               r_count_in   = CNT_PORT_W'(s_ff);
               r_thr_in     = cur_thr_ff;
               r_pvalid_in  = 1'b0;
               r_x_in       = '0;
               r_y_in       = '0;
               r_kind_in    = '0;
               r_last_in    = 1'b0;
            end
         end
         ST_SCR: begin
            bm_raddr = IW'(scan_ff);
            if (scan_ff >= det_total_ff) begin
               pt_ok_in = 1'b0;
            end
         end
         ST_SCC: begin
            if (bm_rdata) begin
               pt_ok_in  = 1'b1;
               kind_in   = edge_kind;
               nb_idx_in = NB_UP;
            end else begin
               scan_in = scan_ff + NW'(1);
               if (sx_last) begin
                  sx_in = '0;
                  sy_in = sy_ff + YW'(1);
               end else begin
                  sx_in = sx_ff + XW'(1);
               end
            end
         end
         ST_NBR: begin
            unique case (nb_idx_ff)
               NB_UP:    bm_raddr = IW'(scan_ff) - IW'(det_w_ff);
               NB_DOWN:  bm_raddr = IW'(scan_ff) + IW'(det_w_ff);
               NB_LEFT:  bm_raddr = IW'(scan_ff) - IW'(1);
               NB_RIGHT: bm_raddr = IW'(scan_ff) + IW'(1);
               default:  bm_raddr = IW'(scan_ff);
            endcase
         end
         ST_NBC: begin
            nb_in[nb_idx_ff] = bm_rdata;
            nb_idx_in = nb_idx_ff + 2'd1;
         end
         ST_KIND: begin
            if (nb_ff == 4'b0000) begin
               kind_in = KIND_ISOLATED;
            end else if (!nb_ff[NB_LEFT] && !nb_ff[NB_RIGHT]) begin
               kind_in = KIND_HORIZONTAL;
            end else if (!nb_ff[NB_UP] && !nb_ff[NB_DOWN]) begin
               kind_in = KIND_VERTICAL;
            end else if (!nb_ff[NB_UP]) begin
               kind_in = KIND_UP;
            end else if (!nb_ff[NB_RIGHT]) begin
               kind_in = KIND_RIGHT;
            end else if (!nb_ff[NB_LEFT]) begin
               kind_in = KIND_LEFT;
            end else if (!nb_ff[NB_DOWN]) begin
               kind_in = KIND_DOWN;
            end else begin
               kind_in = KIND_SURROUNDED;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               r_done_in    = 1'b1;
               r_count_in   = CNT_PORT_W'(found_ff);
               r_thr_in     = cur_thr_ff;
               r_pvalid_in  = pt_ok_ff;
               r_x_in       = pt_ok_ff ? COORD_PORT_W'(sx_ff) : '0;
               r_y_in       = pt_ok_ff ? COORD_PORT_W'(sy_ff) : '0;
               r_kind_in    = pt_ok_ff ? kind_ff : '0;
               r_last_in    = pt_ok_ff && (read_idx_ff + NW'(1) == found_ff);
               if (pt_ok_ff) begin
                  read_idx_in = read_idx_ff + NW'(1);
                  scan_in     = scan_ff + NW'(1);
                  if (sx_last) begin
                     sx_in = '0;
                     sy_in = sy_ff + YW'(1);
                  end else begin
                     sx_in = sx_ff + XW'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= RST_BASE_THRESHOLD;
         max_bad_ff   <= RST_MAX_BAD_COUNT;
         fw_ff        <= RST_FRAME_WIDTH;
         fh_ff        <= RST_FRAME_HEIGHT;
         load_idx_ff  <= '0;
         finished_ff  <= 1'b0;
         found_ff     <= '0;
         cur_thr_ff   <= '0;
         read_idx_ff  <= '0;
         scan_ff      <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         det_w_ff     <= WDW'(MIN_DIM);
         det_h_ff     <= HDW'(MIN_DIM);
         det_total_ff <= NW'(MIN_DIM * MIN_DIM);
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_idx_ff  <= load_idx_in;
         finished_ff  <= finished_in;
         found_ff     <= found_in;
         cur_thr_ff   <= cur_thr_in;
         read_idx_ff  <= read_idx_in;
         scan_ff      <= scan_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         det_w_ff     <= det_w_in;
         det_h_ff     <= det_h_in;
         det_total_ff <= det_total_in;
         va_ff        <= va_in;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_BASE_THRESHOLD: base_ff    <= csr_wdata[BASE_THR_W-1:0];
               CSR_MAX_BAD_COUNT:  max_bad_ff <= csr_wdata[MAX_BAD_W-1:0];
               CSR_FRAME_WIDTH:    fw_ff      <= csr_wdata[DIM_W-1:0];
               CSR_FRAME_HEIGHT:   fh_ff      <= csr_wdata[DIM_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      cx_ff <= cx_in;  cy_ff <= cy_in;  pos_ff <= pos_in;
      big_ff <= big_in;
      wx_ff <= wx_in;  wy_ff <= wy_in;  iss_done_ff <= iss_done_in;
      cnt_ff <= cnt_in;  cons_ff <= cons_in;  k_ff <= k_in;
      prefix_ff <= prefix_in;  mask_ff <= mask_in;  bsel_ff <= bsel_in;
      pix_ff <= pix_in;  d_ff <= d_in;  idx_ff <= idx_in;
      ra_row_ff <= ra_row_in;  ra_col_ff <= ra_col_in;
      addr_ff <= IW'(prod);
      acc_ff <= acc_in;  s_ff <= s_in;  pass_ff <= pass_in;
      thr_ff <= thr_in;  used_ff <= used_in;
      nb_ff <= nb_in;  nb_idx_ff <= nb_idx_in;  kind_ff <= kind_in;  pt_ok_ff <= pt_ok_in;
      r_done_ff <= r_done_in;  r_count_ff <= r_count_in;  r_thr_ff <= r_thr_in;
      r_pvalid_ff <= r_pvalid_in;  r_x_ff <= r_x_in;  r_y_ff <= r_y_in;
      r_kind_ff <= r_kind_in;  r_last_ff <= r_last_in;
   end

   // The frame store takes each loaded sample and feeds the window reads.
   mdpd_ram #(.Width(PB), .Depth(NPIX)) u_frame (
      .clock   (clock),
      .wr_en   (fr_we),
      .wr_addr (fr_waddr),
      .wr_data (req_pixel_value[PB-1:0]),
      .rd_addr (addr_ff),
      .rd_data (fr_rdata)
   );

   // Absolute deviation of every pixel from its median.
   mdpd_ram #(.Width(PB), .Depth(NPIX)) u_dev (
      .clock   (clock),
      .wr_en   (dv_we),
      .wr_addr (pos_ff),
      .wr_data (dev_val),
      .rd_addr (pos_ff),
      .rd_data (dv_rdata)
   );

   // The bad map is rewritten in full by every detection.
   mdpd_ram #(.Width(1), .Depth(NPIX)) u_bad (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (pos_ff),
      .wr_data (bm_wdata),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   // Deviation histogram, turned into counts of at least each level.
   mdpd_ram #(.Width(NW), .Depth(NLEVEL)) u_hist (
      .clock   (clock),
      .wr_en   (hg_we),
      .wr_addr (hg_waddr),
      .wr_data (hg_wdata),
      .rd_addr (hg_raddr),
      .rd_data (hg_rdata)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_detect_done     = r_done_ff;
   assign rsp_bad_count       = r_count_ff;
   assign rsp_final_threshold = r_thr_ff;
   assign rsp_point_valid     = r_pvalid_ff;
   assign rsp_point_x         = r_x_ff;
   assign rsp_point_y         = r_y_ff;
   assign rsp_point_type      = r_kind_ff;
   assign rsp_list_end        = r_last_ff;

   // A point is only ever reported once detection has finished.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_valid |-> rsp_detect_done)
      else $error("point reported without finished detection");

   // The end-of-list flag always comes with a point.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_end |-> rsp_point_valid)
      else $error("list end without a point");

   // The read position never passes the number of bad points found.
   assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> read_idx_ff <= found_ff)
      else $error("read position beyond bad count");

   // Finishing detection always leaves a result in the output register.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && out_free |=> rsp_valid_ff && finished_ff)
      else $error("detection finished without a result");

endmodule
